// ===== hw/rtl/imu_motion_orientation_detector_assert.svh =====
// Assertion macros for the IMU motion and orientation detector.
`ifndef IMU_MOTION_ORIENTATION_DETECTOR_ASSERT_SVH
`define IMU_MOTION_ORIENTATION_DETECTOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define IMOD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define IMOD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/imod_pkg.sv =====
// Shared constants and codes for the IMU motion and orientation detector.
package imod_pkg;

    localparam int SAMPLE_BITS_DEF      = 16;
    localparam int STILL_COUNT_BITS_DEF = 8;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int THR_W     = 16;
    localparam int REQ_W     = 8;
    localparam int GRAV_W    = 15;
    localparam int MAG_W     = 16;
    localparam int ORIENT_W  = 3;

    // result packing: moving, stable, orient, flat, magnitude, change
    localparam int OUT_FIELDS_W = 1 + 1 + ORIENT_W + 1 + MAG_W + MAG_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MOTION_THR  = 3'd0,
        REG_STABLE_THR  = 3'd1,
        REG_STABLE_REQ  = 3'd2,
        REG_GRAV_MIN    = 3'd3,
        REG_GRAV_MAX    = 3'd4,
        REG_OTHER_MAX   = 3'd5
    } t_reg_idx;

    typedef enum logic [ORIENT_W-1:0] {
        ORIENT_Z_UP   = 3'd0,
        ORIENT_Z_DOWN = 3'd1,
        ORIENT_X_UP   = 3'd2,
        ORIENT_X_DOWN = 3'd3,
        ORIENT_Y_UP   = 3'd4,
        ORIENT_Y_DOWN = 3'd5,
        ORIENT_TILTED = 3'd6
    } t_orient;

    localparam logic [THR_W-1:0]  MOTION_THR_RST = 16'd50;
    localparam logic [THR_W-1:0]  STABLE_THR_RST = 16'd15;
    localparam logic [REQ_W-1:0]  STABLE_REQ_RST = 8'd10;
    localparam logic [GRAV_W-1:0] GRAV_MIN_RST   = 15'd920;
    localparam logic [GRAV_W-1:0] GRAV_MAX_RST   = 15'd1050;
    localparam logic [GRAV_W-1:0] OTHER_MAX_RST  = 15'd350;

    localparam logic [MAG_W-1:0] MAG_MAX = '1;

endpackage

// ===== hw/rtl/imu_motion_orientation_detector.sv =====
// Top level of the IMU motion/stillness and orientation detector.
//
//  channel   | direction | signals                              | content
//  ----------+-----------+--------------------------------------+------------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_s_axis_tready/data | lin_accel xyz, grav xyz
//  m_axis    | out       | o_m_axis_tvalid/i_m_axis_tready/data | flags, orientation, magnitude
//  cfg       | in        | i_cfg_valid/o_cfg_ready/addr/data    | threshold register writes
//
// A sample goes from the accept in ST_IDLE through bit-serial squaring (ST_SQUARE), summing
// (ST_ADD_XY, ST_ADD_Z) and a bit-serial square root (ST_ROOT) to the result update in
// ST_FINISH. A new sample is taken only in ST_IDLE, once the last one has left ST_FINISH.
// The result register frees the core: a finished sample waits only if the previous result
// is still held by a stalled m_axis. Reset is synchronous, active low, and restores the
// register defaults and clears motion state. Config writes are always taken.
module imu_motion_orientation_detector #(
    parameter int SAMPLE_BITS      = imod_pkg::SAMPLE_BITS_DEF,
    parameter int STILL_COUNT_BITS = imod_pkg::STILL_COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // lin_accel_x, lin_accel_y, lin_accel_z, grav_x, grav_y, grav_z, zero fill
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]  i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // is_moving, is_stable, orient_code[2:0], lying_flat, accel_magnitude[15:0],
    // magnitude_change[15:0], zero fill
    output logic [imod_pkg::OUT_W-1:0]          o_m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [imod_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [imod_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import imod_pkg::*;

    localparam int S      = SAMPLE_BITS;
    localparam int SQ_W   = 2 * S;
    localparam int REM_W  = S + 3;
    localparam int CNT_W  = $clog2(S);
    localparam int SC_W   = STILL_COUNT_BITS;
    localparam int ROOT_W = (S > MAG_W) ? S : MAG_W;
    localparam int CMP_W  = (SC_W > REQ_W) ? SC_W : REQ_W;
    localparam int GC_W   = (S > GRAV_W) ? S : GRAV_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(S - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ADD_XY,
        ST_ADD_Z,
        ST_ROOT,
        ST_FINISH
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;

    logic [THR_W-1:0]  r_motion_thr;
    logic [THR_W-1:0]  r_stable_thr;
    logic [REQ_W-1:0]  r_stable_req;
    logic [GRAV_W-1:0] r_grav_min;
    logic [GRAV_W-1:0] r_grav_max;
    logic [GRAV_W-1:0] r_other_max;

    logic [MAG_W-1:0]  r_prev_mag;
    logic              r_moving;
    logic [SC_W-1:0]   r_still_cnt;

    logic              r_out_valid;
    logic              r_out_moving;
    logic              r_out_stable;
    t_orient           r_out_orient;
    logic              r_out_flat;
    logic [MAG_W-1:0]  r_out_mag;
    logic [MAG_W-1:0]  r_out_change;

    // datapath: three squaring lanes, square root shifter
    logic [S-1:0]      r_mplr   [3];
    logic [SQ_W-1:0]   r_mcand  [3];
    logic [SQ_W-1:0]   r_sq     [3];
    logic [S-1:0]      r_gabs   [3];
    logic [2:0]        r_gneg;
    logic [SQ_W-1:0]   r_opnd;
    logic [REM_W-1:0]  r_rem;
    logic [S-1:0]      r_root;

    logic              in_xfer;
    logic              out_free;
    logic [S-1:0]      in_abs   [6];
    logic [REM_W-1:0]  n_rem_shift;
    logic [REM_W-1:0]  n_trial;
    logic [ROOT_W-1:0] root_ext;
    logic [MAG_W-1:0]  n_mag;
    logic [MAG_W-1:0]  n_change;
    logic              n_moving;
    logic [SC_W-1:0]   n_still_cnt;
    logic [SC_W-1:0]   cnt_inc;
    logic              n_stable;
    t_orient           n_orient;
    logic [GC_W-1:0]   g_ext    [3];
    logic [2:0]        g_band;
    logic [2:0]        g_small;

    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_change, r_out_mag, r_out_flat, r_out_orient,
                                     r_out_stable, r_out_moving});

    // magnitude of each two's complement field; the most negative value maps to 2^(S-1)
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            in_abs[i] = i_s_axis_tdata[i*S+S-1] ? (~i_s_axis_tdata[i*S +: S] + 1'b1)
                                                : i_s_axis_tdata[i*S +: S];
        end
    end

    // one restoring square root step: bring in two operand bits, try (root<<2)|1
    assign n_rem_shift = {r_rem[REM_W-3:0], r_opnd[SQ_W-1 -: 2]};
    assign n_trial     = REM_W'({r_root, 2'b01});

    always_comb begin
        root_ext = ROOT_W'(r_root);
        n_mag    = (root_ext > ROOT_W'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];
        n_change = (n_mag >= r_prev_mag) ? (n_mag - r_prev_mag) : (r_prev_mag - n_mag);
        cnt_inc  = (r_still_cnt != '1) ? (r_still_cnt + 1'b1) : r_still_cnt;

        n_moving    = r_moving;
        n_still_cnt = r_still_cnt;
        priority if (n_change > r_motion_thr) begin
            n_moving    = 1'b1;
            n_still_cnt = '0;
        end else if (n_change < r_stable_thr) begin
            n_still_cnt = cnt_inc;
            if (r_moving && (CMP_W'(cnt_inc) >= CMP_W'(r_stable_req))) begin
                n_moving = 1'b0;
            end
        end else begin
            // decay between the thresholds, never below zero
            if (r_still_cnt != '0) begin
                n_still_cnt = r_still_cnt - 1'b1;
            end
        end
        n_stable = !n_moving && (CMP_W'(n_still_cnt) >= CMP_W'(r_stable_req));
    end

    // orientation: Z first, then X, then Y; a negative aligned axis reads as up
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            g_ext[i]   = GC_W'(r_gabs[i]);
            g_band[i]  = (g_ext[i] > GC_W'(r_grav_min)) && (g_ext[i] < GC_W'(r_grav_max));
            g_small[i] = g_ext[i] < GC_W'(r_other_max);
        end
        priority if (g_band[2] && g_small[0] && g_small[1]) begin
            n_orient = r_gneg[2] ? ORIENT_Z_UP : ORIENT_Z_DOWN;
        end else if (g_band[0] && g_small[1] && g_small[2]) begin
            n_orient = r_gneg[0] ? ORIENT_X_UP : ORIENT_X_DOWN;
        end else if (g_band[1] && g_small[0] && g_small[2]) begin
            n_orient = r_gneg[1] ? ORIENT_Y_UP : ORIENT_Y_DOWN;
        end else begin
            n_orient = ORIENT_TILTED;
        end
    end

    // control, configuration and motion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_motion_thr <= MOTION_THR_RST;
            r_stable_thr <= STABLE_THR_RST;
            r_stable_req <= STABLE_REQ_RST;
            r_grav_min   <= GRAV_MIN_RST;
            r_grav_max   <= GRAV_MAX_RST;
            r_other_max  <= OTHER_MAX_RST;
            r_prev_mag   <= '0;
            r_moving     <= 1'b0;
            r_still_cnt  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_addr)
                    REG_MOTION_THR: r_motion_thr <= i_cfg_data;
                    REG_STABLE_THR: r_stable_thr <= i_cfg_data;
                    REG_STABLE_REQ: r_stable_req <= i_cfg_data[REQ_W-1:0];
                    REG_GRAV_MIN:   r_grav_min   <= i_cfg_data[GRAV_W-1:0];
                    REG_GRAV_MAX:   r_grav_max   <= i_cfg_data[GRAV_W-1:0];
                    REG_OTHER_MAX:  r_other_max  <= i_cfg_data[GRAV_W-1:0];
                    default: ;
                endcase
            end

            // load a finished sample, else drop the result once its transfer is done
            if ((r_state == ST_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_state <= ST_SQUARE;
                        r_cnt   <= CNT_LAST;
                    end
                end
                ST_SQUARE: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ST_ADD_XY;
                    end
                end
                ST_ADD_XY: r_state <= ST_ADD_Z;
                ST_ADD_Z: begin
                    r_state <= ST_ROOT;
                    r_cnt   <= CNT_LAST;
                end
                ST_ROOT: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // hold until the result register can take this sample
                    if (out_free) begin
                        r_state     <= ST_IDLE;
                        r_prev_mag  <= n_mag;
                        r_moving    <= n_moving;
                        r_still_cnt <= n_still_cnt;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    for (int i = 0; i < 3; i++) begin
                        r_mplr[i]  <= in_abs[i];
                        r_mcand[i] <= SQ_W'(in_abs[i]);
                        r_sq[i]    <= '0;
                        r_gabs[i]  <= in_abs[i+3];
                        r_gneg[i]  <= i_s_axis_tdata[(i+3)*S+S-1];
                    end
                end
            end
            ST_SQUARE: begin
                // add the shifted multiplicand where the multiplier bit is set
                for (int i = 0; i < 3; i++) begin
                    if (r_mplr[i][0]) begin
                        r_sq[i] <= r_sq[i] + r_mcand[i];
                    end
                    r_mplr[i]  <= r_mplr[i] >> 1;
                    r_mcand[i] <= r_mcand[i] << 1;
                end
            end
            ST_ADD_XY: r_sq[0] <= r_sq[0] + r_sq[1];
            ST_ADD_Z: begin
                r_opnd <= r_sq[0] + r_sq[2];
                r_rem  <= '0;
                r_root <= '0;
            end
            ST_ROOT: begin
                r_opnd <= r_opnd << 2;
                if (n_rem_shift >= n_trial) begin
                    r_rem  <= n_rem_shift - n_trial;
                    r_root <= {r_root[S-2:0], 1'b1};
                end else begin
                    r_rem  <= n_rem_shift;
                    r_root <= {r_root[S-2:0], 1'b0};
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    r_out_moving <= n_moving;
                    r_out_stable <= n_stable;
                    r_out_orient <= n_orient;
                    r_out_flat   <= (n_orient != ORIENT_TILTED);
                    r_out_mag    <= n_mag;
                    r_out_change <= n_change;
                end
            end
            default: ;
        endcase
    end

`include "imu_motion_orientation_detector_assert.svh"

    `IMOD_ASSERT_SAME(a_not_moving_and_stable, r_out_valid, !(r_out_moving && r_out_stable),
        "result reports moving and stable together")
    `IMOD_ASSERT_SAME(a_flat_matches_orient, r_out_valid,
        r_out_flat == (r_out_orient != ORIENT_TILTED), "lying_flat disagrees with orientation")
    `IMOD_ASSERT_NEXT(a_square_to_sum, (r_state == ST_SQUARE) && (r_cnt == '0),
        r_state == ST_ADD_XY, "squaring did not hand over to the sum")
    `IMOD_ASSERT_NEXT(a_finish_writes_result, (r_state == ST_FINISH) && out_free,
        r_out_valid && (r_state == ST_IDLE), "finished sample not written to result register")

endmodule

// ===== test/imod_report_check.sv =====
// Result checker for the IMU motion and orientation detector: predicts each report and compares.
`timescale 1ns / 1ps

module imod_report_check
    import imod_pkg::*;
(
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_axis_tvalid,
    input  logic                                        i_s_axis_tready,
    // lin_accel_x, lin_accel_y, lin_accel_z, grav_x, grav_y, grav_z
    input  logic [((6*SAMPLE_BITS_DEF+7)/8)*8-1:0]      i_s_axis_tdata,
    input  logic                                        i_m_axis_tvalid,
    input  logic                                        i_m_axis_tready,
    // is_moving, is_stable, orient_code[2:0], lying_flat, accel_magnitude, magnitude_change
    input  logic [OUT_W-1:0]                            i_m_axis_tdata,
    input  logic                                        i_cfg_valid,
    input  logic                                        i_cfg_ready,
    input  logic [CFG_ADDR_W-1:0]                       i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]                       i_cfg_data,
    output int                                          o_errors,
    output int                                          o_outstanding
);

    typedef struct {
        logic           moving;
        logic           stable;
        t_orient        orient;
        logic           flat;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] change;
    } motion_report_t;

    motion_report_t pending_reports[$];
    int             mismatches = 0;

    // register copies
    logic [THR_W-1:0]  motion_thr;
    logic [THR_W-1:0]  stable_thr;
    logic [REQ_W-1:0]  still_req;
    logic [GRAV_W-1:0] grav_lo;
    logic [GRAV_W-1:0] grav_hi;
    logic [GRAV_W-1:0] side_lim;

    // motion state
    logic [MAG_W-1:0]  prev_mag;
    logic              moving;
    logic [7:0]        still_cnt;

    function automatic logic [16:0] axis_abs(logic [15:0] v);
        logic signed [16:0] w;
        w = $signed({v[15], v});
        return (w < 0) ? -w : w;
    endfunction

    // bit-by-bit search for the largest root whose square fits
    function automatic logic [MAG_W-1:0] floor_root(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 17; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return (root > 65535) ? MAG_MAX : root[MAG_W-1:0];
    endfunction

    function automatic logic in_flat_band(logic [16:0] a);
        return (a > grav_lo) && (a < grav_hi);
    endfunction

    // priority Z, X, Y; a negative aligned axis points up
    function automatic t_orient grav_orient(logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
        logic [16:0] mx;
        logic [16:0] my;
        logic [16:0] mz;
        mx = axis_abs(gx);
        my = axis_abs(gy);
        mz = axis_abs(gz);
        if (in_flat_band(mz) && mx < side_lim && my < side_lim)
            return gz[15] ? ORIENT_Z_UP : ORIENT_Z_DOWN;
        if (in_flat_band(mx) && my < side_lim && mz < side_lim)
            return gx[15] ? ORIENT_X_UP : ORIENT_X_DOWN;
        if (in_flat_band(my) && mx < side_lim && mz < side_lim)
            return gy[15] ? ORIENT_Y_UP : ORIENT_Y_DOWN;
        return ORIENT_TILTED;
    endfunction

    task automatic predict_report(input logic [((6*SAMPLE_BITS_DEF+7)/8)*8-1:0] d);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned az;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] diff;
        motion_report_t   r;
        ax   = axis_abs(d[15:0]);
        ay   = axis_abs(d[31:16]);
        az   = axis_abs(d[47:32]);
        mag  = floor_root(ax * ax + ay * ay + az * az);
        diff = (mag >= prev_mag) ? mag - prev_mag : prev_mag - mag;
        if (diff > motion_thr) begin
            moving    = 1'b1;
            still_cnt = '0;
        end else if (diff < stable_thr) begin
            if (still_cnt != 8'hFF)
                still_cnt++;
            if (moving && still_cnt >= still_req)
                moving = 1'b0;
        end else if (still_cnt != 0) begin
            still_cnt--;
        end
        r.moving = moving;
        r.stable = !moving && (still_cnt >= still_req);
        r.orient = grav_orient(d[63:48], d[79:64], d[95:80]);
        r.flat   = (r.orient != ORIENT_TILTED);
        r.mag    = mag;
        r.change = diff;
        prev_mag = mag;
        pending_reports.push_back(r);
    endtask

    task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        motion_report_t r;
        if (!i_rst_n) begin
            motion_thr = MOTION_THR_RST;
            stable_thr = STABLE_THR_RST;
            still_req  = STABLE_REQ_RST;
            grav_lo    = GRAV_MIN_RST;
            grav_hi    = GRAV_MAX_RST;
            side_lim   = OTHER_MAX_RST;
            prev_mag   = '0;
            moving     = 1'b0;
            still_cnt  = '0;
            pending_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    REG_MOTION_THR: motion_thr = i_cfg_data;
                    REG_STABLE_THR: stable_thr = i_cfg_data;
                    REG_STABLE_REQ: still_req  = i_cfg_data[REQ_W-1:0];
                    REG_GRAV_MIN:   grav_lo    = i_cfg_data[GRAV_W-1:0];
                    REG_GRAV_MAX:   grav_hi    = i_cfg_data[GRAV_W-1:0];
                    REG_OTHER_MAX:  side_lim   = i_cfg_data[GRAV_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected, expected none actual %h",
                             $time, i_m_axis_tdata);
                end else begin
                    r = pending_reports.pop_front();
                    cmp_field("is_moving", r.moving, i_m_axis_tdata[0]);
                    cmp_field("is_stable", r.stable, i_m_axis_tdata[1]);
                    cmp_field("orient_code", r.orient, i_m_axis_tdata[4:2]);
                    cmp_field("lying_flat", r.flat, i_m_axis_tdata[5]);
                    cmp_field("accel_magnitude", r.mag, i_m_axis_tdata[21:6]);
                    cmp_field("magnitude_change", r.change, i_m_axis_tdata[37:22]);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                predict_report(i_s_axis_tdata);
        end
        o_errors      <= mismatches;
        o_outstanding <= pending_reports.size();
    end

endmodule

// ===== test/imu_motion_orientation_detector_tb.sv =====
// Stimulus and verdict for the IMU motion and orientation detector.
`timescale 1ns / 1ps

module imu_motion_orientation_detector_tb;
    import imod_pkg::*;

    localparam int IN_W        = ((6*SAMPLE_BITS_DEF+7)/8)*8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_7 = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_W-1:0]       i_s_axis_tdata  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      o_m_axis_tdata;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    int          err_cnt;
    int          outstanding;
    int unsigned cycle_cnt = 0;
    int          tx_mode   = 1;
    int          rx_mode   = 1;
    int          rx_stall  = 0;

    // register values as last written, used only to aim the stimulus
    int sh_motion = 50;
    int sh_stable = 15;
    int sh_req    = 10;
    int sh_glo    = 920;
    int sh_ghi    = 1050;
    int sh_side   = 350;
    int cur_mag   = 0;

    int phase_items[6] = '{180, 150, 300, 170, 180, 170};

    imu_motion_orientation_detector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    imod_report_check report_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (err_cnt),
        .o_outstanding   (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // output stalls: mostly short, a few long, none in rx_mode 0
    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall        <= rx_stall - 1;
            i_m_axis_tready <= 1'b0;
        end else if (rx_mode != 0 && $urandom_range(99) < 20) begin
            rx_stall        <= ($urandom_range(99) < 12) ? $urandom_range(60, 10) - 1
                                                         : $urandom_range(4, 1) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [IN_W-1:0] pack_sample(int lx, int ly, int lz,
                                                    int gx, int gy, int gz);
        return {16'(gz), 16'(gy), 16'(gx), 16'(lz), 16'(ly), 16'(lx)};
    endfunction

    function automatic int clamp_mag(int v);
        return (v < 0) ? 0 : (v > 32767) ? 32767 : v;
    endfunction

    function automatic int signed_mag(int m);
        return $urandom_range(1) ? -m : m;
    endfunction

    function automatic int tx_gap();
        int r;
        r = $urandom_range(99);
        if (tx_mode == 0 || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(4, 1);
        return $urandom_range(80, 10);
    endfunction

    task automatic send_sample(input logic [IN_W-1:0] d);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (addr)
            REG_MOTION_THR: sh_motion = data;
            REG_STABLE_THR: sh_stable = data;
            REG_STABLE_REQ: sh_req    = data[REQ_W-1:0];
            REG_GRAV_MIN:   sh_glo    = data[GRAV_W-1:0];
            REG_GRAV_MAX:   sh_ghi    = data[GRAV_W-1:0];
            REG_OTHER_MAX:  sh_side   = data[GRAV_W-1:0];
            default: ;
        endcase
    endtask

    // hold the input side until every outstanding report has come back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic set_phase(input int p);
        case (p)
            1: begin
                write_reg(REG_MOTION_THR, 16'd0);
                write_reg(REG_STABLE_THR, 16'd0);
                write_reg(REG_STABLE_REQ, 16'd0);
                write_reg(REG_GRAV_MIN, 16'd0);
                write_reg(REG_GRAV_MAX, 16'hFFFF);
                write_reg(REG_OTHER_MAX, 16'hFFFF);
                write_reg(REG_UNUSED_6, 16'($urandom));
            end
            2: begin
                // every change counts as still: the counter runs into saturation
                write_reg(REG_MOTION_THR, 16'hFFFF);
                write_reg(REG_STABLE_THR, 16'hFFFF);
                write_reg(REG_STABLE_REQ, 16'hFFFF);
                write_reg(REG_GRAV_MIN, 16'h7FFF);
                write_reg(REG_GRAV_MAX, 16'd0);
                write_reg(REG_OTHER_MAX, 16'd0);
            end
            3: begin
                // thresholds overlap, and the flat band overlaps the side limit
                write_reg(REG_MOTION_THR, 16'd20);
                write_reg(REG_STABLE_THR, 16'd60);
                write_reg(REG_STABLE_REQ, 16'd3);
                write_reg(REG_GRAV_MIN, 16'd500);
                write_reg(REG_GRAV_MAX, 16'd1500);
                write_reg(REG_OTHER_MAX, 16'd600);
            end
            4: begin
                write_reg(REG_MOTION_THR, 16'($urandom_range(400, 0)));
                write_reg(REG_STABLE_THR, 16'($urandom_range(100, 0)));
                write_reg(REG_STABLE_REQ, 16'($urandom_range(30, 0)));
                write_reg(REG_GRAV_MIN, 16'($urandom_range(1000, 800)));
                write_reg(REG_GRAV_MAX, 16'($urandom_range(1200, 1000)));
                write_reg(REG_OTHER_MAX, 16'($urandom_range(600, 100)));
                write_reg(REG_UNUSED_7, 16'($urandom));
            end
            5: begin
                // defaults again, with the unused upper bits set
                write_reg(REG_MOTION_THR, 16'd50);
                write_reg(REG_STABLE_THR, 16'd15);
                write_reg(REG_STABLE_REQ, 16'hFF00 | 16'd10);
                write_reg(REG_GRAV_MIN, 16'h8000 | 16'd920);
                write_reg(REG_GRAV_MAX, 16'h8000 | 16'd1050);
                write_reg(REG_OTHER_MAX, 16'h8000 | 16'd350);
            end
            default: ;
        endcase
    endtask

    task automatic pick_accel(output int lx, output int ly, output int lz);
        int sel;
        int d;
        int m;
        int axis;
        int v[3];
        sel = $urandom_range(99);
        if (sel < 8) begin
            v[0] = $urandom_range(65535) - 32768;
            v[1] = $urandom_range(65535) - 32768;
            v[2] = $urandom_range(65535) - 32768;
            cur_mag = clamp_mag(int'($sqrt(real'(v[0]) * v[0] + real'(v[1]) * v[1]
                                           + real'(v[2]) * v[2])));
        end else begin
            sel = $urandom_range(99);
            if (sel < 50)
                d = (sh_stable > 0) ? $urandom_range(sh_stable - 1, 0) : 0;
            else if (sel < 65)
                d = (sh_stable <= sh_motion) ? $urandom_range(sh_motion, sh_stable)
                                             : $urandom_range(300, 0);
            else if (sel < 80)
                d = sh_motion + $urandom_range(200, 1);
            else if (sel < 90)
                case ($urandom_range(3))
                    0: d = sh_stable - 1;
                    1: d = sh_stable;
                    2: d = sh_motion;
                    default: d = sh_motion + 1;
                endcase
            else
                d = $urandom_range(32767, 0);
            if ($urandom_range(1) && cur_mag >= d)
                m = cur_mag - d;
            else
                m = cur_mag + d;
            if (m > 32767)
                m = (cur_mag >= d) ? cur_mag - d : 32767;
            m = clamp_mag(m);
            v = '{0, 0, 0};
            axis = $urandom_range(2);
            v[axis] = signed_mag(m);
            if ($urandom_range(3) == 0)
                v[(axis + 1) % 3] = $urandom_range(2) - 1;
            cur_mag = m;
        end
        lx = v[0];
        ly = v[1];
        lz = v[2];
    endtask

    task automatic pick_gravity(output int gx, output int gy, output int gz);
        int sel;
        int axis;
        int lo;
        int hi;
        int g[3];
        sel  = $urandom_range(99);
        axis = $urandom_range(2);
        lo   = sh_glo + 1;
        hi   = sh_ghi - 1;
        if (sel < 55) begin
            for (int i = 0; i < 3; i++)
                g[i] = (sh_side > 0) ? $urandom_range(sh_side - 1, 0) : 0;
            g[axis] = (hi >= lo) ? $urandom_range(hi, lo) : $urandom_range(32767, 0);
        end else if (sel < 75) begin
            // band and side-limit edges
            for (int i = 0; i < 3; i++)
                case ($urandom_range(2))
                    0: g[i] = sh_side - 1;
                    1: g[i] = sh_side;
                    default: g[i] = 0;
                endcase
            case ($urandom_range(3))
                0: g[axis] = sh_glo;
                1: g[axis] = sh_glo + 1;
                2: g[axis] = sh_ghi - 1;
                default: g[axis] = sh_ghi;
            endcase
        end else if (sel < 82) begin
            // several axes qualify at once where band and side limit overlap
            if (sh_side - 1 < hi)
                hi = sh_side - 1;
            for (int i = 0; i < 3; i++)
                g[i] = (hi >= lo) ? $urandom_range(hi, lo) : $urandom_range(1500, 0);
        end else if (sel < 92) begin
            for (int i = 0; i < 3; i++)
                g[i] = $urandom_range(1500, 0);
        end else begin
            for (int i = 0; i < 3; i++)
                g[i] = -1;
        end
        for (int i = 0; i < 3; i++)
            g[i] = (g[i] < 0 && sel >= 92) ? $urandom_range(65535) - 32768
                                            : signed_mag(clamp_mag(g[i]));
        gx = g[0];
        gy = g[1];
        gz = g[2];
    endtask

    task automatic send_random(input int n);
        int lx, ly, lz, gx, gy, gz;
        repeat (n) begin
            pick_accel(lx, ly, lz);
            pick_gravity(gx, gy, gz);
            send_sample(pack_sample(lx, ly, lz, gx, gy, gz));
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes and every orientation under reset settings
        send_sample(pack_sample(0, 0, 0, 0, 0, -980));
        send_sample(pack_sample(32767, 32767, 32767, 0, 0, 980));
        send_sample(pack_sample(-32768, -32768, -32768, -980, 0, 0));
        send_sample(pack_sample(-32768, 0, 0, 980, 0, 0));
        send_sample(pack_sample(0, -32768, 0, 0, -980, 0));
        send_sample(pack_sample(0, 0, -32768, 0, 980, 0));
        send_sample(pack_sample(100, 0, 0, 600, 600, 600));
        send_sample(pack_sample(100, 0, 0, -32768, -32768, -32768));
        send_sample(pack_sample(100, 0, 0, 349, -349, 921));
        send_sample(pack_sample(100, 0, 0, 350, 0, 1049));
        send_sample(pack_sample(100, 0, 0, 0, 0, 920));
        send_sample(pack_sample(100, 0, 0, 0, 0, -1050));
        send_sample(pack_sample(100, -1, 1, 32767, 0, 0));
        // still run clears motion, then decay and the motion threshold itself
        for (int i = 0; i < 6; i++)
            send_sample(pack_sample(100 + i % 3, 0, 0, 0, 0, -980));
        send_sample(pack_sample(117, 0, 0, 0, 0, -980));
        send_sample(pack_sample(152, 0, 0, 0, 0, -980));
        send_sample(pack_sample(202, 0, 0, 0, 0, -980));
        send_sample(pack_sample(253, 0, 0, 0, 0, -980));
        cur_mag = 253;

        for (int p = 0; p < 6; p++) begin
            drain();
            set_phase(p);
            tx_mode = (p == 2) ? 0 : ($urandom_range(3) != 0);
            rx_mode = (p == 2) ? 0 : ($urandom_range(3) != 0);
            send_random(phase_items[p]);
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
